>>> src/irc_tok_pkg.sv
package irc_tok_pkg;

   // Tokenizer position within the line, one-hot.
   typedef enum logic [6:0] {
      S_LEAD         = 7'b0000001,
      S_TAGS         = 7'b0000010,
      S_AFTER_TAGS   = 7'b0000100,
      S_PREFIX       = 7'b0001000,
      S_AFTER_PREFIX = 7'b0010000,
      S_CMD          = 7'b0100000,
      S_PARAMS       = 7'b1000000
   } section_type;

   // Field kinds reported with each result.
   localparam logic [2:0] K_NAME   = 3'd0;
   localparam logic [2:0] K_VALUE  = 3'd1;
   localparam logic [2:0] K_PREFIX = 3'd2;
   localparam logic [2:0] K_CMD    = 3'd3;
   localparam logic [2:0] K_PARAM  = 3'd4;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_S      = 8'h73;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;

   localparam logic [11:0] VEND_MAX  = 12'hFFF;
   localparam logic [7:0]  PIDX_MAX  = 8'hFF;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  data;
      logic        bvalid;
      logic        fend;
      logic        client;
      logic [11:0] vend;
      logic [7:0]  pidx;
      logic        mend;
      logic        rlast;
   } result_type;

   function automatic result_type mk_result(input logic [2:0] kind,
                                            input logic [7:0] data,
                                            input logic bvalid,
                                            input logic fend,
                                            input logic client,
                                            input logic [11:0] vend,
                                            input logic [7:0] pidx);
      result_type r;
      r.kind   = kind;
      r.data   = bvalid ? data : 8'd0;
      r.bvalid = bvalid;
      r.fend   = fend;
      r.client = client;
      r.vend   = vend;
      r.pidx   = pidx;
      r.mend   = 1'b0;
      r.rlast  = 1'b0;
      return r;
   endfunction

   // Tag value escape decoding for the byte after a backslash.
   function automatic logic [7:0] unescape(input logic [7:0] b);
      logic [7:0] r;
      case (b)
         CH_S:     r = CH_SPACE;
         CH_COLON: r = CH_SEMI;
         CH_R:     r = CH_CR;
         CH_N:     r = CH_LF;
         default:  r = b;
      endcase
      return r;
   endfunction

endpackage

>>> src/irc_message_line_tokenizer.sv
// The results of a byte are registered; the first is offered in the cycle after the byte is accepted.
// Throughput: one byte per cycle while each byte yields at most one result and the receiver
// takes every result; a byte that yields two or three results holds off the next byte until
// its earlier results have been taken, since the output stage hands out at most one result per cycle.
// Reset (synchronous, active high) returns the tokenizer to line start and empties
// the result buffer.
module irc_message_line_tokenizer
   import irc_tok_pkg::*;
#(
   parameter int TAG_NAME_MAX = 4095
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_line,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_field_kind,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_field_end,
   output logic        rsp_client_tag,
   output logic [11:0] rsp_vendor_length,
   output logic [7:0]  rsp_param_index,
   output logic        rsp_message_end,
   output logic        rsp_run_last
);

   // Width of the tag name length and slash position counters.
   localparam int NW = $clog2(TAG_NAME_MAX + 1);

   // Tokenizer state.
   section_type      section_ff, section_in;
   logic             field_open_ff, field_open_in;
   logic             in_value_ff, in_value_in;
   logic             escape_ff, escape_in;
   logic             client_ff, client_in;
   logic [NW-1:0]    name_len_ff, name_len_in;
   logic [NW-1:0]    slash_pos_ff, slash_pos_in;
   logic [7:0]       param_cnt_ff, param_cnt_in;
   logic             trailing_ff, trailing_in;

   // Result buffer: slot 0 is the beat on the output; the buffer shifts down
   // as beats are taken.
   result_type       slot_ff [3];
   result_type       slot_in [3];
   logic [1:0]       count_ff, count_in;

   // Results produced by the byte on the input this cycle.
   result_type       res_in [3];
   logic [1:0]       n_res;
   logic             plus_drop;

   logic             req_fire;
   logic             rsp_fire;

   // Vendor part length reported at a tag name end: the position of the last
   // slash, when that slash is neither the first nor the last byte of the name.
   function automatic logic [11:0] vendor_of(input logic [NW-1:0] sp,
                                             input logic [NW-1:0] nl);
      logic [11:0] v;
      v = 12'd0;
      if ((sp != '0) && ((NW + 1)'(sp) + (NW + 1)'(1) < (NW + 1)'(nl))) begin
         if (32'(sp) > 32'(VEND_MAX)) begin
            v = VEND_MAX;
         end else begin
            v = 12'(sp);
         end
      end
      return v;
   endfunction

   assign rsp_fire  = rsp_valid && rsp_ready;
   // A new byte may enter once the buffer is empty or its last beat leaves now.
   assign req_ready = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_ready);
   assign req_fire  = req_valid && req_ready;

   // Single pass over one byte: next state and up to three results.
   always_comb begin
      section_in    = section_ff;
      field_open_in = field_open_ff;
      in_value_in   = in_value_ff;
      escape_in     = escape_ff;
      client_in     = client_ff;
      name_len_in   = name_len_ff;
      slash_pos_in  = slash_pos_ff;
      param_cnt_in  = param_cnt_ff;
      trailing_in   = trailing_ff;
      plus_drop     = 1'b0;
      n_res         = 2'd0;
      for (int i = 0; i < 3; i++) begin
         res_in[i] = '0;
      end

      case (section_ff)
         S_LEAD, S_AFTER_TAGS: begin
            if (req_data_byte != CH_SPACE) begin
               if ((req_data_byte == CH_AT) && (section_ff == S_LEAD)) begin
                  section_in    = S_TAGS;
                  field_open_in = 1'b0;
               end else if (req_data_byte == CH_COLON) begin
                  section_in    = S_PREFIX;
                  field_open_in = 1'b1;
               end else begin
                  section_in    = S_CMD;
                  field_open_in = 1'b1;
                  res_in[n_res] = mk_result(K_CMD, req_data_byte, 1'b1, 1'b0, 1'b0,
                                            12'd0, 8'd0);
                  n_res = n_res + 2'd1;
               end
            end
         end
         S_TAGS: begin
            if (req_data_byte inside {CH_SPACE, CH_SEMI}) begin
               // Separator: close an open tag; empty tags give nothing.
               if (field_open_in) begin
                  if (!in_value_in) begin
                     res_in[n_res] = mk_result(K_NAME, 8'd0, 1'b0, 1'b1, client_in,
                                               vendor_of(slash_pos_in, name_len_in), 8'd0);
                     n_res = n_res + 2'd1;
                  end
                  res_in[n_res] = mk_result(K_VALUE, 8'd0, 1'b0, 1'b1, 1'b0, 12'd0, 8'd0);
                  n_res = n_res + 2'd1;
                  field_open_in = 1'b0;
                  in_value_in   = 1'b0;
                  escape_in     = 1'b0;
               end
               if (req_data_byte == CH_SPACE) begin
                  section_in = S_AFTER_TAGS;
               end
            end else begin
               // First byte of a tag clears the per-tag state; a plus sign
               // there marks a client tag and is dropped.
               if (!field_open_in) begin
                  field_open_in = 1'b1;
                  in_value_in   = 1'b0;
                  escape_in     = 1'b0;
                  client_in     = 1'b0;
                  name_len_in   = '0;
                  slash_pos_in  = '0;
                  if (req_data_byte == CH_PLUS) begin
                     client_in = 1'b1;
                     plus_drop = 1'b1;
                  end
               end
               if (!plus_drop) begin
                  if (!in_value_in) begin
                     if (req_data_byte == CH_EQUAL) begin
                        // The first equal sign ends the name; both the name end
                        // and a value end beat are reported here.
                        res_in[n_res] = mk_result(K_NAME, 8'd0, 1'b0, 1'b1, client_in,
                                                  vendor_of(slash_pos_in, name_len_in),
                                                  8'd0);
                        n_res = n_res + 2'd1;
                        res_in[n_res] = mk_result(K_VALUE, 8'd0, 1'b0, 1'b1, 1'b0,
                                                  12'd0, 8'd0);
                        n_res = n_res + 2'd1;
                        field_open_in = 1'b1;
                        in_value_in   = 1'b1;
                        escape_in     = 1'b0;
                     end else begin
                        if (req_data_byte == CH_SLASH) begin
                           slash_pos_in = name_len_in;
                        end
                        if (32'(name_len_in) < 32'(TAG_NAME_MAX)) begin
                           name_len_in = name_len_in + NW'(1);
                        end
                        res_in[n_res] = mk_result(K_NAME, req_data_byte, 1'b1, 1'b0, 1'b0,
                                                  12'd0, 8'd0);
                        n_res = n_res + 2'd1;
                     end
                  end else if (escape_in) begin
                     escape_in     = 1'b0;
                     res_in[n_res] = mk_result(K_VALUE, unescape(req_data_byte), 1'b1,
                                               1'b0, 1'b0, 12'd0, 8'd0);
                     n_res = n_res + 2'd1;
                  end else if (req_data_byte == CH_BSLASH) begin
                     escape_in = 1'b1;
                  end else begin
                     res_in[n_res] = mk_result(K_VALUE, req_data_byte, 1'b1, 1'b0, 1'b0,
                                               12'd0, 8'd0);
                     n_res = n_res + 2'd1;
                  end
               end
            end
         end
         S_PREFIX: begin
            if (req_data_byte == CH_SPACE) begin
               res_in[n_res] = mk_result(K_PREFIX, 8'd0, 1'b0, 1'b1, 1'b0, 12'd0, 8'd0);
               n_res = n_res + 2'd1;
               field_open_in = 1'b0;
               section_in    = S_AFTER_PREFIX;
            end else begin
               res_in[n_res] = mk_result(K_PREFIX, req_data_byte, 1'b1, 1'b0, 1'b0,
                                         12'd0, 8'd0);
               n_res = n_res + 2'd1;
            end
         end
         S_AFTER_PREFIX: begin
            if (req_data_byte != CH_SPACE) begin
               section_in    = S_CMD;
               field_open_in = 1'b1;
               res_in[n_res] = mk_result(K_CMD, req_data_byte, 1'b1, 1'b0, 1'b0,
                                         12'd0, 8'd0);
               n_res = n_res + 2'd1;
            end
         end
         S_CMD: begin
            if (req_data_byte == CH_SPACE) begin
               res_in[n_res] = mk_result(K_CMD, 8'd0, 1'b0, 1'b1, 1'b0, 12'd0, 8'd0);
               n_res = n_res + 2'd1;
               field_open_in = 1'b0;
               section_in    = S_PARAMS;
            end else begin
               res_in[n_res] = mk_result(K_CMD, req_data_byte, 1'b1, 1'b0, 1'b0,
                                         12'd0, 8'd0);
               n_res = n_res + 2'd1;
            end
         end
         default: begin
            // Parameters. A leading colon starts the trailing parameter, which
            // keeps spaces as content until the line ends.
            section_in = S_PARAMS;
            if (!field_open_in) begin
               if (req_data_byte != CH_SPACE) begin
                  field_open_in = 1'b1;
                  if (req_data_byte == CH_COLON) begin
                     trailing_in = 1'b1;
                  end else begin
                     trailing_in   = 1'b0;
                     res_in[n_res] = mk_result(K_PARAM, req_data_byte, 1'b1, 1'b0, 1'b0,
                                               12'd0, param_cnt_in);
                     n_res = n_res + 2'd1;
                  end
               end
            end else if ((req_data_byte == CH_SPACE) && !trailing_in) begin
               res_in[n_res] = mk_result(K_PARAM, 8'd0, 1'b0, 1'b1, 1'b0, 12'd0,
                                         param_cnt_in);
               n_res = n_res + 2'd1;
               field_open_in = 1'b0;
               if (param_cnt_in != PIDX_MAX) begin
                  param_cnt_in = param_cnt_in + 8'd1;
               end
            end else begin
               res_in[n_res] = mk_result(K_PARAM, req_data_byte, 1'b1, 1'b0, 1'b0,
                                         12'd0, param_cnt_in);
               n_res = n_res + 2'd1;
            end
         end
      endcase

      // End of line: close whatever field is still open.
      if (req_end_of_line && field_open_in) begin
         if (section_in == S_TAGS) begin
            if (!in_value_in) begin
               res_in[n_res] = mk_result(K_NAME, 8'd0, 1'b0, 1'b1, client_in,
                                         vendor_of(slash_pos_in, name_len_in), 8'd0);
               n_res = n_res + 2'd1;
            end
            res_in[n_res] = mk_result(K_VALUE, 8'd0, 1'b0, 1'b1, 1'b0, 12'd0, 8'd0);
            n_res = n_res + 2'd1;
         end else if (section_in == S_PREFIX) begin
            res_in[n_res] = mk_result(K_PREFIX, 8'd0, 1'b0, 1'b1, 1'b0, 12'd0, 8'd0);
            n_res = n_res + 2'd1;
         end else if (section_in == S_CMD) begin
            res_in[n_res] = mk_result(K_CMD, 8'd0, 1'b0, 1'b1, 1'b0, 12'd0, 8'd0);
            n_res = n_res + 2'd1;
         end else if (section_in == S_PARAMS) begin
            res_in[n_res] = mk_result(K_PARAM, 8'd0, 1'b0, 1'b1, 1'b0, 12'd0,
                                      param_cnt_in);
            n_res = n_res + 2'd1;
         end
      end

      // A line end that produced nothing still gets one empty marker beat.
      if (req_end_of_line && (n_res == 2'd0)) begin
         res_in[0] = mk_result(K_NAME, 8'd0, 1'b0, 1'b0, 1'b0, 12'd0, 8'd0);
         n_res     = 2'd1;
      end

      // Flag the last beat of this byte, and of the line on a line end.
      for (int i = 0; i < 3; i++) begin
         if (n_res == 2'(i + 1)) begin
            res_in[i].rlast = 1'b1;
            res_in[i].mend  = req_end_of_line;
         end
      end

      // After the final byte everything returns to line start.
      if (req_end_of_line) begin
         section_in    = S_LEAD;
         field_open_in = 1'b0;
         in_value_in   = 1'b0;
         escape_in     = 1'b0;
         client_in     = 1'b0;
         name_len_in   = '0;
         slash_pos_in  = '0;
         param_cnt_in  = 8'd0;
         trailing_in   = 1'b0;
      end
   end

   // Result buffer next value. A byte is only taken when the buffer is empty
   // after this cycle, so loading simply overwrites the slots.
   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      slot_in[2] = slot_ff[2];
      count_in   = count_ff;
      if (req_fire) begin
         slot_in[0] = res_in[0];
         slot_in[1] = res_in[1];
         slot_in[2] = res_in[2];
         count_in   = n_res;
      end else if (rsp_fire) begin
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
         count_in   = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         section_ff    <= S_LEAD;
         field_open_ff <= 1'b0;
         in_value_ff   <= 1'b0;
         escape_ff     <= 1'b0;
         client_ff     <= 1'b0;
         name_len_ff   <= '0;
         slash_pos_ff  <= '0;
         param_cnt_ff  <= 8'd0;
         trailing_ff   <= 1'b0;
         count_ff      <= 2'd0;
      end else begin
         if (req_fire) begin
            section_ff    <= section_in;
            field_open_ff <= field_open_in;
            in_value_ff   <= in_value_in;
            escape_ff     <= escape_in;
            client_ff     <= client_in;
            name_len_ff   <= name_len_in;
            slash_pos_ff  <= slash_pos_in;
            param_cnt_ff  <= param_cnt_in;
            trailing_ff   <= trailing_in;
         end
         count_ff <= count_in;
      end
   end

   // Payload slots carry no reset; count_ff qualifies them.
   always_ff @(posedge clock) begin
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
      slot_ff[2] <= slot_in[2];
   end

   assign rsp_valid         = (count_ff != 2'd0);
   assign rsp_field_kind    = slot_ff[0].kind;
   assign rsp_out_byte      = slot_ff[0].data;
   assign rsp_byte_valid    = slot_ff[0].bvalid;
   assign rsp_field_end     = slot_ff[0].fend;
   assign rsp_client_tag    = slot_ff[0].client;
   assign rsp_vendor_length = slot_ff[0].vend;
   assign rsp_param_index   = slot_ff[0].pidx;
   assign rsp_message_end   = slot_ff[0].mend;
   assign rsp_run_last      = slot_ff[0].rlast;

endmodule

>>> sim/tb_irc_message_line_tokenizer.sv
`timescale 1ns / 100ps

module tb_irc_message_line_tokenizer
   import irc_tok_pkg::*;
();

   // Tag name lengths saturate at this value in both the block and the predictor below.
   localparam int TAG_NAME_LIMIT = 4095;

   // One beat of the input channel: a raw byte and its end-of-line marker.
   typedef struct packed {
      logic [7:0] data;
      logic       eol;
   } line_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_end_of_line = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_field_kind;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic        rsp_field_end;
   logic        rsp_client_tag;
   logic [11:0] rsp_vendor_length;
   logic [7:0]  rsp_param_index;
   logic        rsp_message_end;
   logic        rsp_run_last;

   irc_message_line_tokenizer #(
      .TAG_NAME_MAX(TAG_NAME_LIMIT)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_end_of_line  (req_end_of_line),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_field_kind   (rsp_field_kind),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_field_end    (rsp_field_end),
      .rsp_client_tag   (rsp_client_tag),
      .rsp_vendor_length(rsp_vendor_length),
      .rsp_param_index  (rsp_param_index),
      .rsp_message_end  (rsp_message_end),
      .rsp_run_last     (rsp_run_last)
   );

   always #6 clock = ~clock;

   // Stimulus and scoreboard storage.
   line_beat_type line_beats[$];      // bytes still to be offered to the block
   logic [7:0]  line_buf[$];          // line under construction
   result_type  token_run[$];         // results of the byte being predicted
   result_type  expected_tokens[$];   // predicted results not yet seen on the output

   int          mismatches = 0;
   int unsigned cycle_count = 0;
   int unsigned cycle_limit = 32'h7FFF_FFFF;

   // Driver and receiver pacing.
   logic        req_beat_done = 1'b0;
   int          req_gap = 0;
   int          req_calm = 0;
   int          rsp_hold = 0;
   int          rsp_calm = 0;

   // Predictor copy of the tokenizer state.
   section_type sect;
   bit          fld_open;
   bit          in_value;
   bit          esc_wait;
   bit          plus_tag;
   bit          trail_param;
   int unsigned name_len;
   int unsigned slash_at;
   int unsigned param_ord;

   // ------------------------------------------------------------------
   // Tokenizer predictor
   // ------------------------------------------------------------------

   function automatic void clear_state();
      sect        = S_LEAD;
      fld_open    = 1'b0;
      in_value    = 1'b0;
      esc_wait    = 1'b0;
      plus_tag    = 1'b0;
      trail_param = 1'b0;
      name_len    = 0;
      slash_at    = 0;
      param_ord   = 0;
   endfunction

   // Appends one result to the run of the current byte. The byte lane is zero
   // whenever no content byte is carried, and the vendor length saturates.
   function automatic void emit(input logic [2:0] kind, input logic [7:0] data,
                                input bit has_byte, input bit closes, input bit client,
                                input int unsigned vend, input int unsigned pidx);
      result_type r;
      r.kind   = kind;
      r.data   = has_byte ? data : 8'd0;
      r.bvalid = has_byte;
      r.fend   = closes;
      r.client = client;
      r.vend   = (vend > VEND_MAX) ? VEND_MAX : vend[11:0];
      r.pidx   = pidx[7:0];
      r.mend   = 1'b0;
      r.rlast  = 1'b0;
      token_run.push_back(r);
   endfunction

   // Closes a tag. A tag still in its name reports the name end first, with the
   // client flag and the vendor length; a value end always follows.
   function automatic void finish_tag();
      int unsigned vlen;
      if (!in_value) begin
         vlen = (slash_at > 0 && slash_at + 1 < name_len) ? slash_at : 0;
         emit(K_NAME, 8'd0, 1'b0, 1'b1, plus_tag, vlen, 0);
      end
      emit(K_VALUE, 8'd0, 1'b0, 1'b1, 1'b0, 0, 0);
      fld_open = 1'b0;
      in_value = 1'b0;
      esc_wait = 1'b0;
   endfunction

   function automatic logic [7:0] decode_escape(input logic [7:0] c);
      case (c)
         CH_S:     return CH_SPACE;
         CH_COLON: return CH_SEMI;
         CH_R:     return CH_CR;
         CH_N:     return CH_LF;
         default:  return c;
      endcase
   endfunction

   // One byte inside the tags field that is neither a space nor a semicolon.
   function automatic void tag_content(input logic [7:0] b);
      if (!fld_open) begin
         fld_open = 1'b1;
         in_value = 1'b0;
         esc_wait = 1'b0;
         plus_tag = 1'b0;
         name_len = 0;
         slash_at = 0;
         // The plus sign that marks a client tag is not part of the name.
         if (b == CH_PLUS) begin
            plus_tag = 1'b1;
            return;
         end
      end
      if (!in_value) begin
         // Only the first equal sign splits name from value.
         if (b == CH_EQUAL) begin
            finish_tag();
            fld_open = 1'b1;
            in_value = 1'b1;
            return;
         end
         if (b == CH_SLASH)
            slash_at = name_len;
         if (name_len < TAG_NAME_LIMIT)
            name_len++;
         emit(K_NAME, b, 1'b1, 1'b0, 1'b0, 0, 0);
         return;
      end
      if (esc_wait) begin
         esc_wait = 1'b0;
         emit(K_VALUE, decode_escape(b), 1'b1, 1'b0, 1'b0, 0, 0);
         return;
      end
      if (b == CH_BSLASH) begin
         esc_wait = 1'b1;
         return;
      end
      emit(K_VALUE, b, 1'b1, 1'b0, 1'b0, 0, 0);
   endfunction

   // Works out every result that one accepted input beat causes and queues them.
   function automatic void predict_tokens(input logic [7:0] b, input logic eol);
      int last;
      token_run.delete();
      case (sect)
         S_LEAD, S_AFTER_TAGS: begin
            if (b != CH_SPACE) begin
               if (b == CH_AT && sect == S_LEAD) begin
                  sect     = S_TAGS;
                  fld_open = 1'b0;
               end else if (b == CH_COLON) begin
                  sect     = S_PREFIX;
                  fld_open = 1'b1;
               end else begin
                  sect     = S_CMD;
                  fld_open = 1'b1;
                  emit(K_CMD, b, 1'b1, 1'b0, 1'b0, 0, 0);
               end
            end
         end
         S_TAGS: begin
            if (b == CH_SPACE || b == CH_SEMI) begin
               if (fld_open)
                  finish_tag();
               if (b == CH_SPACE)
                  sect = S_AFTER_TAGS;
            end else begin
               tag_content(b);
            end
         end
         S_PREFIX: begin
            if (b == CH_SPACE) begin
               emit(K_PREFIX, 8'd0, 1'b0, 1'b1, 1'b0, 0, 0);
               fld_open = 1'b0;
               sect     = S_AFTER_PREFIX;
            end else begin
               emit(K_PREFIX, b, 1'b1, 1'b0, 1'b0, 0, 0);
            end
         end
         S_AFTER_PREFIX: begin
            if (b != CH_SPACE) begin
               sect     = S_CMD;
               fld_open = 1'b1;
               emit(K_CMD, b, 1'b1, 1'b0, 1'b0, 0, 0);
            end
         end
         S_CMD: begin
            if (b == CH_SPACE) begin
               emit(K_CMD, 8'd0, 1'b0, 1'b1, 1'b0, 0, 0);
               fld_open = 1'b0;
               sect     = S_PARAMS;
            end else begin
               emit(K_CMD, b, 1'b1, 1'b0, 1'b0, 0, 0);
            end
         end
         default: begin
            sect = S_PARAMS;
            if (!fld_open) begin
               if (b != CH_SPACE) begin
                  fld_open = 1'b1;
                  // A leading colon makes this the trailing parameter; the colon
                  // itself is dropped.
                  if (b == CH_COLON) begin
                     trail_param = 1'b1;
                  end else begin
                     trail_param = 1'b0;
                     emit(K_PARAM, b, 1'b1, 1'b0, 1'b0, 0, param_ord);
                  end
               end
            end else if (b == CH_SPACE && !trail_param) begin
               emit(K_PARAM, 8'd0, 1'b0, 1'b1, 1'b0, 0, param_ord);
               fld_open = 1'b0;
               if (param_ord < 255)
                  param_ord++;
            end else begin
               emit(K_PARAM, b, 1'b1, 1'b0, 1'b0, 0, param_ord);
            end
         end
      endcase

      if (eol) begin
         if (fld_open) begin
            case (sect)
               S_TAGS:   finish_tag();
               S_PREFIX: emit(K_PREFIX, 8'd0, 1'b0, 1'b1, 1'b0, 0, 0);
               S_CMD:    emit(K_CMD, 8'd0, 1'b0, 1'b1, 1'b0, 0, 0);
               S_PARAMS: emit(K_PARAM, 8'd0, 1'b0, 1'b1, 1'b0, 0, param_ord);
               default: ;
            endcase
         end
         // A line end that produced nothing still gets a bare marker result.
         if (token_run.size() == 0)
            emit(K_NAME, 8'd0, 1'b0, 1'b0, 1'b0, 0, 0);
         token_run[token_run.size() - 1].mend = 1'b1;
         clear_state();
      end
      if (token_run.size() > 0) begin
         last = token_run.size() - 1;
         token_run[last].rlast = 1'b1;
      end
      foreach (token_run[i])
         expected_tokens.push_back(token_run[i]);
   endfunction

   // ------------------------------------------------------------------
   // Line construction
   // ------------------------------------------------------------------

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++)
         line_buf.push_back(s[i]);
   endtask

   // Moves the line under construction into the stimulus, flagging its last byte.
   task automatic commit_line();
      line_beat_type lb;
      foreach (line_buf[i]) begin
         lb.data = line_buf[i];
         lb.eol  = (i == line_buf.size() - 1);
         line_beats.push_back(lb);
      end
      line_buf.delete();
   endtask

   // Mostly lowercase letters, sometimes any printable or high byte. Inside tags
   // the separators and the escape character are kept out so structure stays
   // under the control of the caller.
   function automatic logic [7:0] text_char(input bit in_tag);
      logic [7:0] c;
      do begin
         if ($urandom_range(0, 9) < 7)
            c = 8'(8'h61 + $urandom_range(0, 25));
         else
            c = 8'($urandom_range(8'h21, 8'hFF));
      end while (in_tag && (c == CH_SEMI || c == CH_EQUAL || c == CH_BSLASH));
      return c;
   endfunction

   // Builds a well-formed message with random content: optional tags with
   // escapes, client markers and vendor slashes, optional prefix, a command and
   // up to four parameters, the last one possibly trailing. A few lines are cut
   // short so that the line end falls in every field.
   task automatic build_message();
      int ntags;
      int nlen;
      int vlen;
      int nparams;
      int keep;
      if ($urandom_range(0, 5) == 0)
         put_text(" ");
      if ($urandom_range(0, 1) == 0) begin
         line_buf.push_back(CH_AT);
         ntags = $urandom_range(1, 3);
         for (int t = 0; t < ntags; t++) begin
            if (t > 0 || $urandom_range(0, 7) == 0)
               line_buf.push_back(CH_SEMI);
            if ($urandom_range(0, 7) == 0)
               line_buf.push_back(CH_SEMI);
            if ($urandom_range(0, 3) == 0)
               line_buf.push_back(CH_PLUS);
            nlen = $urandom_range(0, 6);
            for (int i = 0; i < nlen; i++)
               line_buf.push_back(($urandom_range(0, 4) == 0) ? CH_SLASH : text_char(1'b1));
            if ($urandom_range(0, 4) != 0) begin
               line_buf.push_back(CH_EQUAL);
               vlen = $urandom_range(0, 6);
               for (int i = 0; i < vlen; i++) begin
                  case ($urandom_range(0, 5))
                     0: begin
                        line_buf.push_back(CH_BSLASH);
                        // Now and then the backslash is left without a partner.
                        if ($urandom_range(0, 4) != 0) begin
                           case ($urandom_range(0, 5))
                              0: line_buf.push_back(CH_S);
                              1: line_buf.push_back(CH_COLON);
                              2: line_buf.push_back(CH_R);
                              3: line_buf.push_back(CH_N);
                              4: line_buf.push_back(CH_BSLASH);
                              default: line_buf.push_back(text_char(1'b1));
                           endcase
                        end
                     end
                     1: line_buf.push_back(CH_EQUAL);
                     default: line_buf.push_back(text_char(1'b1));
                  endcase
               end
            end
         end
         if ($urandom_range(0, 5) == 0)
            line_buf.push_back(CH_SEMI);
         if ($urandom_range(0, 9) == 0)
            return;
         put_text(" ");
      end
      if ($urandom_range(0, 2) == 0) begin
         line_buf.push_back(CH_COLON);
         nlen = $urandom_range(0, 6);
         for (int i = 0; i < nlen; i++)
            line_buf.push_back(text_char(1'b0));
         put_text(" ");
         if ($urandom_range(0, 3) == 0)
            put_text(" ");
      end
      nlen = $urandom_range(1, 5);
      for (int i = 0; i < nlen; i++)
         line_buf.push_back(text_char(1'b0));
      nparams = $urandom_range(0, 4);
      for (int p = 0; p < nparams; p++) begin
         put_text(" ");
         if ($urandom_range(0, 4) == 0)
            put_text(" ");
         if (p == nparams - 1 && $urandom_range(0, 2) == 0) begin
            line_buf.push_back(CH_COLON);
            vlen = $urandom_range(0, 8);
            for (int i = 0; i < vlen; i++)
               line_buf.push_back(($urandom_range(0, 4) == 0) ? CH_SPACE : text_char(1'b0));
         end else begin
            vlen = $urandom_range(1, 5);
            for (int i = 0; i < vlen; i++)
               line_buf.push_back(text_char(1'b0));
         end
      end
      if ($urandom_range(0, 7) == 0)
         put_text(" ");
      if ($urandom_range(0, 9) == 0) begin
         keep = $urandom_range(1, line_buf.size());
         while (line_buf.size() > keep)
            void'(line_buf.pop_back());
      end
   endtask

   // Short run of arbitrary bytes, biased toward the characters that steer
   // the tokenizer.
   task automatic build_noise();
      int n;
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 7))
               0: line_buf.push_back(CH_SPACE);
               1: line_buf.push_back(CH_COLON);
               2: line_buf.push_back(CH_AT);
               3: line_buf.push_back(CH_SEMI);
               4: line_buf.push_back(CH_EQUAL);
               5: line_buf.push_back(CH_BSLASH);
               6: line_buf.push_back(CH_PLUS);
               default: line_buf.push_back(CH_SLASH);
            endcase
         end else begin
            line_buf.push_back(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // Idle lengths: mostly none or short, a few long, and now and then a calm
   // stretch with no idling at all.
   function automatic int pick_delay(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         calm = $urandom_range(16, 64);
         return 0;
      end
      if (r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(1, 2);
      if (r < 96)
         return $urandom_range(3, 8);
      return $urandom_range(12, 24);
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // ------------------------------------------------------------------
   // Driver: offers the next byte at the falling edge. Valid stays up with a
   // stable payload until the beat is taken, then an optional gap follows.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      line_beat_type lb;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_beat_done) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (line_beats.size() > 0) begin
            lb = line_beats.pop_front();
            req_valid       <= 1'b1;
            req_data_byte   <= lb.data;
            req_end_of_line <= lb.eol;
            req_gap = pick_delay(req_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: ready is withdrawn for random stretches regardless of valid.
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_ready <= 1'b1;
         rsp_hold = pick_delay(rsp_calm);
      end
   end

   // ------------------------------------------------------------------
   // Monitor: at each rising edge an accepted input beat is predicted first,
   // then an accepted result beat is checked against the oldest expectation.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      result_type want;
      cycle_count   <= cycle_count + 1;
      req_beat_done <= req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready)
            predict_tokens(req_data_byte, req_end_of_line);
         if (rsp_valid && rsp_ready) begin
            if (expected_tokens.size() == 0) begin
               $error("result beat with nothing expected: kind %0d byte %0h",
                      rsp_field_kind, rsp_out_byte);
               mismatches++;
            end else begin
               want = expected_tokens.pop_front();
               check_field("field_kind",    16'(want.kind),   16'(rsp_field_kind));
               check_field("out_byte",      16'(want.data),   16'(rsp_out_byte));
               check_field("byte_valid",    16'(want.bvalid), 16'(rsp_byte_valid));
               check_field("field_end",     16'(want.fend),   16'(rsp_field_end));
               check_field("client_tag",    16'(want.client), 16'(rsp_client_tag));
               check_field("vendor_length", 16'(want.vend),   16'(rsp_vendor_length));
               check_field("param_index",   16'(want.pidx),   16'(rsp_param_index));
               check_field("message_end",   16'(want.mend),   16'(rsp_message_end));
               check_field("run_last",      16'(want.rlast),  16'(rsp_run_last));
            end
         end
      end
   end

   // Watchdog on the cycle counter.
   initial begin
      while (cycle_count < cycle_limit)
         @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      clear_state();

      // Directed lines. A client tag with a vendor slash and a value that ends
      // in a lone backslash after an escaped space.
      put_text("@+v/n=\\s\\");
      commit_line();
      // A line of one space yields only the bare line end marker.
      put_text(" ");
      commit_line();
      // Empty prefix followed by a command.
      put_text(": C");
      commit_line();
      // Highest byte value in a command, then an empty trailing parameter.
      line_buf.push_back(8'h43);
      line_buf.push_back(8'hFF);
      put_text(" :");
      commit_line();
      // Zero byte as a command, then two ordinary parameters.
      line_buf.push_back(8'h00);
      put_text(" a b");
      commit_line();
      // Empty tags are dropped; a tag with an empty name whose value starts with
      // a second equal sign.
      put_text("@;a;;==x");
      commit_line();

      // Random lines: mostly well-formed messages, the rest noise.
      while (line_beats.size() < 400) begin
         if ($urandom_range(0, 99) < 85)
            build_message();
         else
            build_noise();
         commit_line();
      end

      // Worst case per beat: three results each behind the longest receiver stall,
      // plus the longest sender gap; then a wide margin on top.
      cycle_limit = line_beats.size() * 320 + 2000;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (line_beats.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_tokens.size() != 0)
         @(posedge clock);
      // Give a misbehaving block time to emit anything extra.
      repeat (16) @(posedge clock);

      if (mismatches == 0 && expected_tokens.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
